### sv/tfn_pkg.sv
// Shared types and constants of the triangle face normal pipeline.
`default_nettype none
package tfn_pkg;

    // Coordinate format and the widths that follow from it.
    localparam int CW    = 24;              // coordinate bits, signed Q8.16
    localparam int EW    = CW + 1;          // edge bits, signed
    localparam int PW    = 2 * EW;          // edge product bits, signed
    localparam int NW    = PW + 1;          // cross component bits, signed
    localparam int MW    = 2 * CW + 1;      // cross component magnitude bits
    localparam int LOW   = (MW + 1) / 2;    // low half of a magnitude
    localparam int HIW   = MW - LOW;        // high half of a magnitude
    localparam int SQW   = 2 * MW;          // squared component bits
    localparam int SW    = SQW + 2;         // squared length bits
    localparam int RW    = SW + 36;         // remainder and accumulator bits, signed
    localparam int QW    = 15;              // rounded magnitude bits
    localparam int OW    = 16;              // output component bits, signed Q1.14
    localparam int SHIFT = 30;              // 2^30 scale of the rounding test
    localparam int TW    = 32;              // threshold bits

    localparam logic [QW-1:0]   UNIT_MAX   = QW'(16384);
    localparam logic [TW-1:0]   THR_RESET  = TW'(4295);
    localparam logic [2*TW-1:0] THR_SQ_RESET = (2*TW)'(THR_RESET) * (2*TW)'(THR_RESET);

    // Pipeline stage numbers.
    localparam int ST_CROSS = 3;                  // last stage of the cross product
    localparam int ST_INIT  = 7;                  // last stage of length and set-up
    localparam int NST      = ST_INIT + QW + 1;   // output register stage

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by_coord;
        logic signed [CW-1:0] bz;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
    } tri_t;

    typedef struct packed {
        logic signed [OW-1:0] normal_x;
        logic signed [OW-1:0] normal_y;
        logic signed [OW-1:0] normal_z;
        logic                 degenerate;
    } norm_t;

    // Cross product as sign and magnitude.
    typedef struct packed {
        logic [2:0][MW-1:0] mag;
        logic [2:0]         neg;
    } cross_t;

    // State of the digit-by-digit rounding search of all three components.
    typedef struct packed {
        logic [2:0][RW-1:0] rem;
        logic [2:0][RW-1:0] acc;
        logic [2:0][QW-1:0] q;
        logic [2:0]         neg;
        logic [SW-1:0]      s;
        logic               deg;
    } rnd_t;

endpackage
`default_nettype wire

### sv/tfn_cross.sv
// Edge vectors and their cross product, three register stages.
`default_nettype none
module tfn_cross (
    input  wire logic                 clk,
    input  wire logic [2:0]           en,
    input  wire tfn_pkg::tri_t        tri_data,
    output tfn_pkg::cross_t           cross_prod
);

    logic [2:0][tfn_pkg::CW-1:0] pa, pb, pc;
    logic [2:0][tfn_pkg::EW-1:0] e1_reg, e2_reg, e1_next, e2_next;
    logic [2:0][tfn_pkg::PW-1:0] u_reg, v_reg, u_next, v_next;
    tfn_pkg::cross_t              cross_reg, cross_next;

    always_comb
    begin
        pa = {tri_data.ax, tri_data.ay, tri_data.az};
        pb = {tri_data.bx, tri_data.by_coord, tri_data.bz};
        pc = {tri_data.cx, tri_data.cy, tri_data.cz};
    end

    // Lane 2 is x, lane 1 is y and lane 0 is z, so lane K2 follows lane k in
    // the x, y, z order and lane K1 follows lane K2.
    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;
        logic signed [tfn_pkg::NW-1:0] nd;
        logic signed [tfn_pkg::PW-1:0] e1_k1, e1_k2, e2_k1, e2_k2;

        assign e1_next[k] = tfn_pkg::EW'($signed(pb[k])) - tfn_pkg::EW'($signed(pa[k]));
        assign e2_next[k] = tfn_pkg::EW'($signed(pc[k])) - tfn_pkg::EW'($signed(pa[k]));

        assign e1_k1 = tfn_pkg::PW'($signed(e1_reg[K1]));
        assign e1_k2 = tfn_pkg::PW'($signed(e1_reg[K2]));
        assign e2_k1 = tfn_pkg::PW'($signed(e2_reg[K1]));
        assign e2_k2 = tfn_pkg::PW'($signed(e2_reg[K2]));

        assign u_next[k] = e1_k2 * e2_k1;
        assign v_next[k] = e1_k1 * e2_k2;

        assign nd = tfn_pkg::NW'($signed(u_reg[k])) - tfn_pkg::NW'($signed(v_reg[k]));
        assign cross_next.neg[k] = nd[tfn_pkg::NW-1];
        assign cross_next.mag[k] = nd[tfn_pkg::NW-1] ? tfn_pkg::MW'(-nd)
                                                      : tfn_pkg::MW'(nd);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            e1_reg <= e1_next;
            e2_reg <= e2_next;
        end
        if (en[1])
        begin
            u_reg <= u_next;
            v_reg <= v_next;
        end
        if (en[2])
        begin
            cross_reg <= cross_next;
        end
    end

    assign cross_prod = cross_reg;

endmodule
`default_nettype wire

### sv/tfn_square.sv
// Squared length, threshold test and set-up of the rounding search, four stages.
`default_nettype none
module tfn_square (
    input  wire logic                        clk,
    input  wire logic [3:0]                  en,
    input  wire tfn_pkg::cross_t             cross_prod,
    input  wire logic [2*tfn_pkg::TW-1:0]    thr_sq,
    output tfn_pkg::rnd_t                    init
);

    logic [2:0][2*tfn_pkg::HIW-1:0]         hh_reg, hh_next;
    logic [2:0][tfn_pkg::HIW+tfn_pkg::LOW-1:0] hl_reg, hl_next;
    logic [2:0][2*tfn_pkg::LOW-1:0]         ll_reg, ll_next;
    logic [2:0]                             neg4_reg, neg5_reg, neg6_reg;
    logic [2:0][tfn_pkg::SQW-1:0]           sq5_reg, sq5_next, sq6_reg;
    logic [tfn_pkg::SW-1:0]                 s_reg, s_next;
    tfn_pkg::rnd_t                          init_reg, init_next;

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic [tfn_pkg::HIW-1:0] h;
        logic [tfn_pkg::LOW-1:0] l;

        // The square is split into halves so each multiplier stays narrow.
        assign h = cross_prod.mag[k][tfn_pkg::MW-1:tfn_pkg::LOW];
        assign l = cross_prod.mag[k][tfn_pkg::LOW-1:0];
        assign hh_next[k] = (2*tfn_pkg::HIW)'(h) * (2*tfn_pkg::HIW)'(h);
        assign hl_next[k] = (tfn_pkg::HIW+tfn_pkg::LOW)'(h) * (tfn_pkg::HIW+tfn_pkg::LOW)'(l);
        assign ll_next[k] = (2*tfn_pkg::LOW)'(l) * (2*tfn_pkg::LOW)'(l);

        assign sq5_next[k] = (tfn_pkg::SQW'(hh_reg[k]) << (2 * tfn_pkg::LOW))
                           + (tfn_pkg::SQW'(hl_reg[k]) << (tfn_pkg::LOW + 1))
                           + tfn_pkg::SQW'(ll_reg[k]);

        assign init_next.rem[k] = (tfn_pkg::RW'(sq6_reg[k]) << tfn_pkg::SHIFT)
                                - tfn_pkg::RW'(s_reg);
        assign init_next.acc[k] = '0;
        assign init_next.q[k]   = '0;
    end

    assign s_next = tfn_pkg::SW'(sq5_reg[0]) + tfn_pkg::SW'(sq5_reg[1])
                  + tfn_pkg::SW'(sq5_reg[2]);

    assign init_next.neg = neg6_reg;
    assign init_next.s   = s_reg;
    assign init_next.deg = (s_reg <= tfn_pkg::SW'(thr_sq));

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            hh_reg   <= hh_next;
            hl_reg   <= hl_next;
            ll_reg   <= ll_next;
            neg4_reg <= cross_prod.neg;
        end
        if (en[1])
        begin
            sq5_reg  <= sq5_next;
            neg5_reg <= neg4_reg;
        end
        if (en[2])
        begin
            s_reg    <= s_next;
            sq6_reg  <= sq5_reg;
            neg6_reg <= neg5_reg;
        end
        if (en[3])
        begin
            init_reg <= init_next;
        end
    end

    assign init = init_reg;

endmodule
`default_nettype wire

### sv/tfn_round_step.sv
// One bit of the rounding search for all three components, one register stage.
`default_nettype none
module tfn_round_step #(
    parameter int STEP = 0
) (
    input  wire logic          clk,
    input  wire logic          en,
    input  wire tfn_pkg::rnd_t cur,
    output tfn_pkg::rnd_t      nxt
);

    tfn_pkg::rnd_t           nxt_reg, nxt_next;
    logic [tfn_pkg::RW-1:0]  s_ext;

    assign s_ext = tfn_pkg::RW'(cur.s);

    // Raising q by b = 2^STEP grows (2q-1)^2 * S by 8b*(q*S) + (4b^2 - 4b)*S.
    // The remainder holds 2^30 * n^2 - (2q-1)^2 * S and acc holds q * S.
    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        logic [tfn_pkg::RW-1:0] delta;
        logic [tfn_pkg::QW-1:0] cand;
        logic                   take;

        assign delta = (cur.acc[k] << (STEP + 3)) + (s_ext << (2 * STEP + 2))
                     - (s_ext << (STEP + 2));
        assign cand  = cur.q[k] | (tfn_pkg::QW'(1) << STEP);
        assign take  = (cand <= tfn_pkg::UNIT_MAX)
                    && ($signed(delta) <= $signed(cur.rem[k]));

        assign nxt_next.rem[k] = take ? cur.rem[k] - delta : cur.rem[k];
        assign nxt_next.acc[k] = take ? cur.acc[k] + (s_ext << STEP) : cur.acc[k];
        assign nxt_next.q[k]   = take ? cand : cur.q[k];
    end

    assign nxt_next.neg = cur.neg;
    assign nxt_next.s   = cur.s;
    assign nxt_next.deg = cur.deg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxt_reg <= nxt_next;
        end
    end

    assign nxt = nxt_reg;

endmodule
`default_nettype wire

### sv/triangle_face_normal.sv
// Top level of the triangle face normal pipeline.
`default_nettype none
// Takes one triangle per beat (three corners, signed Q8.16) and returns its unit
// face normal as three signed Q1.14 components, each rounded to nearest with ties
// away from zero, plus a degenerate flag. The block is a 23-stage pipeline: three
// stages form the edges and the exact cross product, four stages form the squared
// length, compare it with the squared threshold and set up the rounding, fifteen
// stages each settle one bit of the three magnitudes, and the last stage is the
// output register. A new triangle can be accepted in every cycle unless all stages
// are full and the consumer stalls; the fifteen rounding stages set the depth. Each
// stage holds its own valid bit and loads whenever it is empty or the stage after
// it moves, so bubbles close up and input is still taken while a finished result
// waits for the consumer. When the length of the cross product is at or below
// degenerate_threshold (units of 2^-32, reset value 4295) the three components are
// zero and degenerate is set. The threshold is written through the configuration
// channel, which is always ready; write it only while no triangle is in flight.
module triangle_face_normal (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           tri_valid,
    output logic                tri_ready,
    input  wire tfn_pkg::tri_t  tri_data,
    output logic                norm_valid,
    input  wire logic           norm_ready,
    output tfn_pkg::norm_t      norm_data,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic [31:0]    cfg_data
);

    localparam int NST = tfn_pkg::NST;

    logic [NST:1]                 vld_reg;
    logic [NST+1:1]               ld;
    logic [tfn_pkg::TW-1:0]       thr_reg;
    logic [2*tfn_pkg::TW-1:0]     thr_sq_reg;
    tfn_pkg::cross_t              cross_prod;
    tfn_pkg::rnd_t                chain [0:tfn_pkg::QW];
    tfn_pkg::norm_t               out_reg, out_next;

    // Threshold register and its square, which is registered from it in the cycle after.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= tfn_pkg::THR_RESET;
            thr_sq_reg <= tfn_pkg::THR_SQ_RESET;
        end
        else
        begin
            if (cfg_valid)
            begin
                thr_reg <= cfg_data;
            end
            thr_sq_reg <= (2*tfn_pkg::TW)'(thr_reg) * (2*tfn_pkg::TW)'(thr_reg);
        end
    end

    // A stage loads when it is empty or its contents move on.
    assign ld[NST+1] = norm_ready;
    for (genvar i = 1; i <= NST; i++)
    begin : g_ld
        assign ld[i] = !vld_reg[i] || ld[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[1])
            begin
                vld_reg[1] <= tri_valid;
            end
            for (int i = 2; i <= NST; i++)
            begin
                if (ld[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign tri_ready  = ld[1];
    assign norm_valid = vld_reg[NST];

    tfn_cross u_cross (
        .clk        (clk),
        .en         (ld[tfn_pkg::ST_CROSS:1]),
        .tri_data   (tri_data),
        .cross_prod (cross_prod)
    );

    tfn_square u_square (
        .clk        (clk),
        .en         (ld[tfn_pkg::ST_INIT:tfn_pkg::ST_CROSS+1]),
        .cross_prod (cross_prod),
        .thr_sq     (thr_sq_reg),
        .init       (chain[0])
    );

    // Bits of the rounded magnitudes are settled from the top bit down.
    for (genvar j = 0; j < tfn_pkg::QW; j++)
    begin : g_step
        tfn_round_step #(
            .STEP (tfn_pkg::QW - 1 - j)
        ) u_step (
            .clk (clk),
            .en  (ld[tfn_pkg::ST_INIT + 1 + j]),
            .cur (chain[j]),
            .nxt (chain[j+1])
        );
    end

    // Apply the signs; a degenerate triangle gives a zero normal.
    always_comb
    begin
        tfn_pkg::rnd_t fin;
        logic [2:0][tfn_pkg::OW-1:0] comp;
        fin = chain[tfn_pkg::QW];
        for (int k = 0; k < 3; k++)
        begin
            if (fin.deg)
            begin
                comp[k] = '0;
            end
            else if (fin.neg[k])
            begin
                comp[k] = -tfn_pkg::OW'(fin.q[k]);
            end
            else
            begin
                comp[k] = tfn_pkg::OW'(fin.q[k]);
            end
        end
        out_next.normal_x   = comp[2];
        out_next.normal_y   = comp[1];
        out_next.normal_z   = comp[0];
        out_next.degenerate = fin.deg;
    end

    always_ff @(posedge clk)
    begin
        if (ld[NST])
        begin
            out_reg <= out_next;
        end
    end

    assign norm_data = out_reg;

`ifndef SYNTHESIS
    // A degenerate result carries a zero normal.
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        norm_valid && norm_data.degenerate |->
            norm_data.normal_x == 0 && norm_data.normal_y == 0 && norm_data.normal_z == 0)
        else $error("degenerate result with nonzero normal");

    // Every component stays within the unit range.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        norm_valid |->
            norm_data.normal_x >= -16'sd16384 && norm_data.normal_x <= 16'sd16384 &&
            norm_data.normal_y >= -16'sd16384 && norm_data.normal_y <= 16'sd16384 &&
            norm_data.normal_z >= -16'sd16384 && norm_data.normal_z <= 16'sd16384)
        else $error("normal component out of range");

    // Input is refused only when every stage is occupied.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        !tri_ready |-> &vld_reg)
        else $error("input stalled while the pipeline has a bubble");
`endif

endmodule
`default_nettype wire

### tb/tb_triangle_face_normal.sv
// Self-checking testbench for the triangle face normal pipeline.
`timescale 1ns / 100ps

// Scoreboard: predicts the unit normal of every accepted triangle and checks
// each output beat against the oldest prediction.
class normal_scoreboard;
    logic [31:0]           threshold;
    tfn_pkg::norm_t        expected_normals[$];
    int                    mismatches;

    function new();
        threshold  = tfn_pkg::THR_RESET;
        mismatches = 0;
    endfunction

    // Exact cross product, squared-length test and rounded division.
    function tfn_pkg::norm_t compute_normal(tfn_pkg::tri_t t);
        longint          corner[9];
        longint          e1[3];
        longint          e2[3];
        longint          cross_n[3];
        logic [63:0]     mag;
        logic [159:0]    sq[3];
        logic [159:0]    len_sq;
        logic [159:0]    thr_sq;
        logic [159:0]    lim;
        logic [159:0]    prod;
        logic [15:0]     q;
        logic [15:0]     cand;
        logic [31:0]     odd;
        logic [15:0]     comp[3];
        tfn_pkg::norm_t  r;
        corner = '{t.ax, t.ay, t.az, t.bx, t.by_coord, t.bz, t.cx, t.cy, t.cz};
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = corner[3 + i] - corner[i];
            e2[i] = corner[6 + i] - corner[i];
        end
        for (int k = 0; k < 3; k++)
        begin
            cross_n[k] = e1[(k + 1) % 3] * e2[(k + 2) % 3]
                       - e1[(k + 2) % 3] * e2[(k + 1) % 3];
            mag = (cross_n[k] < 0) ? 64'(-cross_n[k]) : 64'(cross_n[k]);
            sq[k] = 160'(mag) * 160'(mag);
        end
        len_sq = sq[0] + sq[1] + sq[2];
        thr_sq = 160'(threshold) * 160'(threshold);
        r = '0;
        if (len_sq <= thr_sq)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        // Largest q up to 16384 with (2q-1)^2 * |N|^2 <= 2^30 * n^2, found bit by bit.
        for (int k = 0; k < 3; k++)
        begin
            lim = sq[k] << 30;
            q = '0;
            for (int b = 14; b >= 0; b--)
            begin
                cand = q | (16'd1 << b);
                if (cand <= 16'd16384)
                begin
                    odd  = 32'(2 * cand - 1);
                    prod = len_sq * 160'(odd * odd);
                    if (prod <= lim)
                        q = cand;
                end
            end
            comp[k] = (cross_n[k] < 0) ? 16'(-int'(q)) : q;
        end
        r.normal_x = comp[0];
        r.normal_y = comp[1];
        r.normal_z = comp[2];
        return r;
    endfunction

    function void note_triangle(tfn_pkg::tri_t t);
        expected_normals = {expected_normals, compute_normal(t)};
    endfunction

    function void check_normal(tfn_pkg::norm_t got);
        tfn_pkg::norm_t exp_n;
        if (expected_normals.size() == 0)
        begin
            $error("output beat with no triangle outstanding: %h", got);
            mismatches++;
            return;
        end
        exp_n = expected_normals.pop_front();
        if (got.normal_x !== exp_n.normal_x)
        begin
            $error("normal_x expected %0d actual %0d", exp_n.normal_x, got.normal_x);
            mismatches++;
        end
        if (got.normal_y !== exp_n.normal_y)
        begin
            $error("normal_y expected %0d actual %0d", exp_n.normal_y, got.normal_y);
            mismatches++;
        end
        if (got.normal_z !== exp_n.normal_z)
        begin
            $error("normal_z expected %0d actual %0d", exp_n.normal_z, got.normal_z);
            mismatches++;
        end
        if (got.degenerate !== exp_n.degenerate)
        begin
            $error("degenerate expected %0b actual %0b", exp_n.degenerate, got.degenerate);
            mismatches++;
        end
    endfunction
endclass

module tb_triangle_face_normal;

    // The pipeline is 23 stages deep; the drain wait leaves margin beyond that.
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_GAP      = 18;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           tri_valid = 1'b0;
    logic           tri_ready;
    tfn_pkg::tri_t  tri_data = '0;
    logic           norm_valid;
    logic           norm_ready = 1'b0;
    tfn_pkg::norm_t norm_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [31:0]    cfg_data = '0;

    normal_scoreboard normals = new();

    // Each side switches now and then between random gaps and back-to-back beats.
    bit send_gaps = 1'b1;
    bit take_gaps = 1'b1;

    always #5 clk = ~clk;

    triangle_face_normal dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .tri_valid  (tri_valid),
        .tri_ready  (tri_ready),
        .tri_data   (tri_data),
        .norm_valid (norm_valid),
        .norm_ready (norm_ready),
        .norm_data  (norm_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    function automatic tfn_pkg::tri_t make_tri(int x0, int y0, int z0, int x1, int y1, int z1,
                                               int x2, int y2, int z2);
        tfn_pkg::tri_t t;
        t.ax = tfn_pkg::CW'(x0); t.ay = tfn_pkg::CW'(y0); t.az = tfn_pkg::CW'(z0);
        t.bx = tfn_pkg::CW'(x1); t.by_coord = tfn_pkg::CW'(y1); t.bz = tfn_pkg::CW'(z1);
        t.cx = tfn_pkg::CW'(x2); t.cy = tfn_pkg::CW'(y2); t.cz = tfn_pkg::CW'(z2);
        return t;
    endfunction

    // Random triangle: full-range corners, tiny triangles around the degenerate
    // threshold, collinear or coincident corners, and mid-sized triangles.
    function automatic tfn_pkg::tri_t random_tri();
        tfn_pkg::tri_t t;
        int   span;
        int   kind;
        int   k;
        kind = $urandom_range(0, 9);
        t = tfn_pkg::tri_t'(($bits(tfn_pkg::tri_t))'({$urandom, $urandom, $urandom,
                                                       $urandom, $urandom, $urandom,
                                                       $urandom}));
        if (kind >= 4)
        begin
            span = (kind < 7) ? 64 : ((kind < 9) ? 65536 : 2);
            t.bx = t.ax + tfn_pkg::CW'($urandom_range(0, 2 * span) - span);
            t.by_coord = t.ay + tfn_pkg::CW'($urandom_range(0, 2 * span) - span);
            t.bz = t.az + tfn_pkg::CW'($urandom_range(0, 2 * span) - span);
            t.cx = t.ax + tfn_pkg::CW'($urandom_range(0, 2 * span) - span);
            t.cy = t.ay + tfn_pkg::CW'($urandom_range(0, 2 * span) - span);
            t.cz = t.az + tfn_pkg::CW'($urandom_range(0, 2 * span) - span);
        end
        else if (kind == 3)
        begin
            // C on the line through A and B, or a repeated corner.
            k = $urandom_range(0, 3);
            t.bx = t.ax + tfn_pkg::CW'($urandom_range(0, 2000) - 1000);
            t.by_coord = t.ay + tfn_pkg::CW'($urandom_range(0, 2000) - 1000);
            t.bz = t.az + tfn_pkg::CW'($urandom_range(0, 2000) - 1000);
            t.cx = t.ax + tfn_pkg::CW'(k) * (t.bx - t.ax);
            t.cy = t.ay + tfn_pkg::CW'(k) * (t.by_coord - t.ay);
            t.cz = t.az + tfn_pkg::CW'(k) * (t.bz - t.az);
        end
        return t;
    endfunction

    // Sends one triangle; valid stays high across back-to-back beats.
    task automatic send_triangle(tfn_pkg::tri_t t);
        int gap;
        gap = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            tri_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tri_valid <= 1'b1;
        tri_data  <= t;
        do
            @(posedge clk);
        while (!tri_ready);
        normals.note_triangle(t);
        if ($urandom_range(0, 40) == 0)
            send_gaps = !send_gaps;
    endtask

    // Writes the threshold once the pipeline has drained.
    task automatic write_threshold(logic [31:0] value);
        tri_valid <= 1'b0;
        wait (normals.expected_normals.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        normals.threshold = value;
    endtask

    // Output side: random stalls, checking every accepted beat.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            gap = take_gaps ? $urandom_range(0, MAX_GAP) : 0;
            if (gap > 0)
            begin
                norm_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            norm_ready <= 1'b1;
            do
                @(posedge clk);
            while (!norm_valid);
            normals.check_normal(norm_data);
            if ($urandom_range(0, 40) == 0)
                take_gaps = !take_gaps;
        end
    end

    // Main sequence: directed corners first, then random phases under several thresholds.
    initial
    begin
        localparam int ONE = 65536;
        localparam int MAXC = 8388607;
        localparam int MINC = -8388608;
        logic [31:0]   settings[4];
        tfn_pkg::tri_t directed[$];

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed = {directed, make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0)};
        directed = {directed, make_tri(0, 0, 0, ONE, 0, 0, 0, ONE, 0)};
        directed = {directed, make_tri(0, 0, 0, 0, ONE, 0, ONE, 0, 0)};
        directed = {directed, make_tri(0, 0, 0, 0, ONE, 0, 0, 0, ONE)};
        directed = {directed, make_tri(0, 0, 0, 0, 0, ONE, ONE, 0, 0)};
        directed = {directed, make_tri(0, 0, 0, ONE, ONE, 0, 0, 0, ONE)};
        directed = {directed, make_tri(0, 0, 0, 3, 0, 0, 0, 1, 4)};
        // Cross product length exactly at the reset threshold, and one above.
        directed = {directed, make_tri(0, 0, 0, 1, 0, 0, 0, 4295, 0)};
        directed = {directed, make_tri(0, 0, 0, 1, 0, 0, 0, 4296, 0)};
        directed = {directed, make_tri(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, MINC, MAXC)};
        directed = {directed, make_tri(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MAXC, MINC)};
        directed = {directed, make_tri(MINC, MAXC, MINC, MAXC, MINC, MINC, MINC, MINC, MAXC)};
        directed = {directed, make_tri(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, MINC)};
        directed = {directed, make_tri(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC)};
        directed = {directed, make_tri(MAXC, 0, 0, 0, MAXC, 0, 0, 0, MAXC)};
        directed = {directed, make_tri(MINC, 0, 0, 0, MINC, 0, 0, 0, MINC)};
        directed = {directed, make_tri(-1, -1, -1, 0, 0, 0, 1, 2, 3)};
        directed = {directed, make_tri(5, 7, 11, 5 + ONE, 7, 11, 5, 7 + 1, 11 + ONE)};
        foreach (directed[i])
            send_triangle(directed[i]);
        repeat (120) send_triangle(random_tri());

        settings = '{32'd0, 32'hFFFF_FFFF, 32'd1, $urandom};
        foreach (settings[p])
        begin
            write_threshold(settings[p]);
            repeat (120) send_triangle(random_tri());
        end
        write_threshold(tfn_pkg::THR_RESET);
        repeat (20) send_triangle(random_tri());
        tri_valid <= 1'b0;

        wait (normals.expected_normals.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (normals.mismatches == 0)
            $display("triangle_face_normal regression: pass");
        else
            $display("triangle_face_normal regression: fail");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #20ms;
        $display("triangle_face_normal regression: fail");
        $finish;
    end
endmodule

### files.f
sv/tfn_pkg.sv
sv/tfn_cross.sv
sv/tfn_square.sv
sv/tfn_round_step.sv
sv/triangle_face_normal.sv
tb/tb_triangle_face_normal.sv
